/* rtl/btt_pkg.sv */
// Shared widths, codes and types of the busy-task top-k tracker.
package btt_pkg;

    localparam int TIME_W  = 64;
    localparam int ID_W    = 15;
    localparam int OP_W    = 2;
    localparam int RANK_W  = 3;
    localparam int SHARE_W = 8;

    localparam int TASK_SLOTS_DEF = 32768;
    localparam int TOP_COUNT_DEF  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_BASE  = 2'd0,
        OP_FRAME = 2'd1,
        OP_CLOSE = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RMW,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] run_time;
        logic [TIME_W-1:0] total;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic [SHARE_W-1:0] share;
    } div_rsp_t;

endpackage

/* rtl/btt_if.sv */
// Valid/ready channel interfaces for samples in and ranked results out.
interface btt_in_if;
    import btt_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ID_W-1:0]   task_id;
    logic [TIME_W-1:0] cumulative_time;
    logic [TIME_W-1:0] frame_total;

    modport source (output valid, op, task_id, cumulative_time, frame_total, input ready);
    modport sink (input valid, op, task_id, cumulative_time, frame_total, output ready);
endinterface

interface btt_out_if;
    import btt_pkg::*;

    logic               valid;
    logic               ready;
    logic [RANK_W-1:0]  rank;
    logic [ID_W-1:0]    top_task;
    logic [TIME_W-1:0]  top_time;
    logic [SHARE_W-1:0] share_percent;
    logic               last;

    modport source (output valid, rank, top_task, top_time, share_percent, last, input ready);
    modport sink (input valid, rank, top_task, top_time, share_percent, last, output ready);
endinterface

/* rtl/btt_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module btt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/btt_div.sv */
// Share unit: floor(run_time * 100 / total) saturated at 255, one quotient bit a cycle.
module btt_div (
    input  logic              clk,
    input  logic              rst_n,
    input  btt_pkg::div_req_t req,
    output btt_pkg::div_rsp_t rsp
);
    import btt_pkg::*;

    localparam int DW     = TIME_W + SHARE_W;
    localparam int STEPS  = SHARE_W;
    localparam int STEP_W = $clog2(STEPS + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DW-1:0]     rem_reg;
    logic [DW-1:0]     dsh_reg;
    logic [SHARE_W-1:0] q_reg;
    logic [DW-1:0]     t_ext;
    logic              ge;

    assign t_ext = DW'(req.run_time);
    assign ge    = rem_reg >= dsh_reg;

    // Step zero checks the product against 256 times the total, which saturates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if ((step_reg == '0 && ge) || step_reg == STEP_W'(STEPS))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= (t_ext << 6) + (t_ext << 5) + (t_ext << 2);
            dsh_reg <= DW'(req.total) << SHARE_W;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (step_reg == '0)
            begin
                if (ge)
                begin
                    q_reg <= '1;
                end
            end
            else
            begin
                q_reg <= {q_reg[SHARE_W-2:0], ge};
                if (ge)
                begin
                    rem_reg <= rem_reg - dsh_reg;
                end
            end
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.share = q_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("share done without a running division");
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("share unit started while busy");
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> step_reg <= STEP_W'(STEPS))
        else $error("share step counter overran");
endmodule

/* rtl/busy_task_top_k_tracker.sv */
// Busy-task top-k tracker: per-task time memory, ranking and frame report.
//
// Usage: items enter on in_ch (valid/ready). op 0 stores a baseline time for
// task_id, op 1 takes the wrapping difference to the stored time, stores the
// new time and offers a nonzero difference to the ranking, op 2 closes the
// frame. Ids at or above TASK_SLOTS and op 3 are taken and ignored.
// A sample reads the time memory when accepted, then writes the new time back in ST_RMW.
// The ranking update of a frame sample overlaps the next item's acceptance.
// A close with a nonzero frame_total sends TOP_COUNT result items on out_ch,
// rank 0 first, last set on the final one; for each item the share unit
// finds one quotient bit per cycle and stops early when the share
// saturates. A close with a zero total sends nothing.
// Either way the ranking is cleared afterwards.
// out_ch holds its item registered until taken; a stalled receiver stalls the
// report and no new item is accepted until the report has gone out.
// After reset the time memory is cleared, one entry a cycle, through all
// TASK_SLOTS entries; in_ch ready stays low during that pass.
module busy_task_top_k_tracker #(
    parameter int TASK_SLOTS = btt_pkg::TASK_SLOTS_DEF,
    parameter int TOP_COUNT  = btt_pkg::TOP_COUNT_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    btt_in_if.sink    in_ch,
    btt_out_if.source out_ch
);
    import btt_pkg::*;

    localparam int AW = $clog2(TASK_SLOTS);
    localparam int RW = (TOP_COUNT > 1) ? $clog2(TOP_COUNT) : 1;

    state_t state_reg, state_next;

    logic [AW-1:0]     clr_addr_reg;
    logic [AW-1:0]     addr_reg;
    logic [TIME_W-1:0] now_reg;
    logic              frame_reg;
    logic [TIME_W-1:0] total_reg;
    logic              off_valid_reg;
    logic [ID_W-1:0]   off_id_reg;
    logic [TIME_W-1:0] off_time_reg;
    logic [RW-1:0]     rank_reg;

    logic [ID_W-1:0]   best_ids_reg   [TOP_COUNT];
    logic [ID_W-1:0]   best_ids_next  [TOP_COUNT];
    logic [TIME_W-1:0] best_times_reg [TOP_COUNT];
    logic [TIME_W-1:0] best_times_next[TOP_COUNT];

    logic [RANK_W-1:0]  out_rank_reg;
    logic [ID_W-1:0]    out_task_reg;
    logic [TIME_W-1:0]  out_time_reg;
    logic [SHARE_W-1:0] out_share_reg;
    logic               out_last_reg;

    logic              accept;
    logic              id_ok;
    logic              clr_done;
    logic              rank_last;
    logic              out_take;
    logic              clear_rank;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [TIME_W-1:0] ram_wdata;
    logic [TIME_W-1:0] prev_time;
    logic [TIME_W-1:0] delta;
    logic              in_ready;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    assign accept    = in_ch.valid && in_ready;
    assign id_ok     = int'(in_ch.task_id) < TASK_SLOTS;
    assign clr_done  = clr_addr_reg == AW'(TASK_SLOTS - 1);
    assign rank_last = rank_reg == RW'(TOP_COUNT - 1);
    assign out_take  = out_ch.valid && out_ch.ready;
    assign delta     = now_reg - prev_time;

    btt_ram #(
        .WIDTH(TIME_W),
        .DEPTH(TASK_SLOTS)
    ) u_prev_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (accept),
        .raddr(AW'(in_ch.task_id)),
        .rdata(prev_time)
    );

    btt_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op_t'(in_ch.op))
                        OP_BASE, OP_FRAME:
                        begin
                            if (id_ok)
                            begin
                                state_next = ST_RMW;
                            end
                        end
                        OP_CLOSE:
                        begin
                            if (in_ch.frame_total != '0)
                            begin
                                state_next = ST_DIV_GO;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RMW:      state_next = ST_IDLE;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_take)
                begin
                    state_next = out_last_reg ? ST_IDLE : ST_DIV_GO;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb
    begin
        in_ready         = state_reg == ST_IDLE;
        ram_we           = (state_reg == ST_CLEAR) || (state_reg == ST_RMW);
        ram_waddr        = (state_reg == ST_CLEAR) ? clr_addr_reg : addr_reg;
        ram_wdata        = (state_reg == ST_CLEAR) ? '0 : now_reg;
        div_req.start    = state_reg == ST_DIV_GO;
        div_req.run_time = best_times_reg[rank_reg];
        div_req.total    = total_reg;
        clear_rank       = (accept && op_t'(in_ch.op) == OP_CLOSE && in_ch.frame_total == '0)
                           || (state_reg == ST_OUT && out_take && out_last_reg);
    end

    // Stable insertion: the new entry goes before the first strictly smaller time.
    // Empty ranks hold zero and a nonzero difference always beats them.
    always_comb
    begin
        logic take;
        logic prev_take;
        prev_take = 1'b0;
        best_ids_next   = best_ids_reg;
        best_times_next = best_times_reg;
        for (int p = 0; p < TOP_COUNT; p++)
        begin
            take = best_times_reg[p] < off_time_reg;
            if (clear_rank)
            begin
                best_ids_next[p]   = '0;
                best_times_next[p] = '0;
            end
            else if (off_valid_reg && take)
            begin
                if (prev_take)
                begin
                    best_ids_next[p]   = best_ids_reg[(p > 0) ? p - 1 : 0];
                    best_times_next[p] = best_times_reg[(p > 0) ? p - 1 : 0];
                end
                else
                begin
                    best_ids_next[p]   = off_id_reg;
                    best_times_next[p] = off_time_reg;
                end
            end
            prev_take = take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            off_valid_reg <= 1'b0;
            rank_reg      <= '0;
            for (int p = 0; p < TOP_COUNT; p++)
            begin
                best_ids_reg[p]   <= '0;
                best_times_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            best_ids_reg   <= best_ids_next;
            best_times_reg <= best_times_next;
            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            off_valid_reg <= (state_reg == ST_RMW) && frame_reg && (delta != '0);
            if (accept)
            begin
                rank_reg <= '0;
            end
            else if (state_reg == ST_OUT && out_take)
            begin
                rank_reg <= rank_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= AW'(in_ch.task_id);
            now_reg   <= in_ch.cumulative_time;
            frame_reg <= op_t'(in_ch.op) == OP_FRAME;
            total_reg <= in_ch.frame_total;
        end
        if (state_reg == ST_RMW)
        begin
            off_id_reg   <= ID_W'(addr_reg);
            off_time_reg <= delta;
        end
        if (state_reg == ST_DIV_WAIT && div_rsp.done)
        begin
            out_rank_reg  <= RANK_W'(rank_reg);
            out_task_reg  <= best_ids_reg[rank_reg];
            out_time_reg  <= best_times_reg[rank_reg];
            out_share_reg <= div_rsp.share;
            out_last_reg  <= rank_last;
        end
    end

    assign in_ch.ready          = in_ready;
    assign out_ch.valid         = state_reg == ST_OUT;
    assign out_ch.rank          = out_rank_reg;
    assign out_ch.top_task      = out_task_reg;
    assign out_ch.top_time      = out_time_reg;
    assign out_ch.share_percent = out_share_reg;
    assign out_ch.last          = out_last_reg;

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in_ch.ready)
        else $error("item accepted during the memory clearing pass");
    a_offer_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        off_valid_reg |-> $past(state_reg) == ST_RMW)
        else $error("ranking offer without a preceding write back");
    a_last_on_final_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.last) |-> out_ch.rank == RANK_W'(TOP_COUNT - 1))
        else $error("last flag on a rank other than the final one");

    for (genvar g = 1; g < TOP_COUNT; g++)
    begin : g_sorted
        a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
            best_times_reg[g-1] >= best_times_reg[g])
            else $error("ranking out of order");
    end
endmodule
